### rtl/core/sec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sec_pkg;

  localparam int FEEDBACK_BITS_DEFAULT = 10;

  localparam int ANGLE_W  = 8;
  localparam int STEP_W   = 7;
  localparam int THRESH_W = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;
  // Signed width that holds an angle plus or minus two steps.
  localparam int SUM_W    = 10;

  localparam logic [THRESH_W-1:0] STALL_THRESHOLD_RESET = 10'd5;
  localparam logic [STEP_W-1:0]   ANGLE_STEP_RESET      = 7'd10;
  localparam logic [ANGLE_W-1:0]  FULL_ANGLE_RESET      = 8'd180;

  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_ANGLE      = 2'd2;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_GO_HIGH = 2'd2,
    OP_GO_LOW  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_UP    = 4'b0010,
    PH_REREF = 4'b0100,
    PH_DOWN  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic               drive_valid;
    logic [ANGLE_W-1:0] drive_angle;
    logic               busy_res;
    logic [ANGLE_W-1:0] low_limit;
    logic [ANGLE_W-1:0] high_limit;
    logic               finished;
  } result_t;

  function automatic logic [ANGLE_W-1:0] clamp_angle(input logic signed [SUM_W-1:0] v,
                                                     input logic [ANGLE_W-1:0] full);
    logic [ANGLE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SUM_W-ANGLE_W){1'b0}}, full})) begin
      r = full;
    end else begin
      r = v[ANGLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/sec_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module sec_in_reg #(
  parameter int FEEDBACK_BITS = sec_pkg::FEEDBACK_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic                         advance,
  input  wire logic [1:0]                   op_d,
  input  wire logic [sec_pkg::ANGLE_W-1:0]  start_angle_d,
  input  wire logic [FEEDBACK_BITS-1:0]     feedback_d,
  output logic                              full,
  output logic [1:0]                        op_q,
  output logic [sec_pkg::ANGLE_W-1:0]       start_angle_q,
  output logic [FEEDBACK_BITS-1:0]          feedback_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_q          <= op_d;
      start_angle_q <= start_angle_d;
      feedback_q    <= feedback_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/sec_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sec_step #(
  parameter int FEEDBACK_BITS = sec_pkg::FEEDBACK_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [sec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sec_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          advance,
  input  wire logic [1:0]                    op,
  input  wire logic [sec_pkg::ANGLE_W-1:0]   start_angle,
  input  wire logic [FEEDBACK_BITS-1:0]      feedback,
  output sec_pkg::result_t                   result
);

  localparam int DW = ((FEEDBACK_BITS > sec_pkg::THRESH_W) ? FEEDBACK_BITS
                                                            : sec_pkg::THRESH_W) + 1;
  localparam int SW = sec_pkg::SUM_W;
  localparam int AW = sec_pkg::ANGLE_W;

  logic [sec_pkg::THRESH_W-1:0] stall_threshold;
  logic [sec_pkg::STEP_W-1:0]   angle_step;
  logic [AW-1:0]                full_angle;

  sec_pkg::phase_t            phase, phase_next;
  logic [AW-1:0]              sweep_angle, sweep_angle_next;
  logic [FEEDBACK_BITS-1:0]   reference_feedback, reference_feedback_next;
  logic [AW-1:0]              lower_limit_reg, lower_limit_reg_next;
  logic [AW-1:0]              upper_limit_reg, upper_limit_reg_next;

  logic signed [SW-1:0] a_s, st_s, st2_s, start_s;
  logic [AW-1:0]        plus1, plus2, minus1, minus2, start_plus;
  logic signed [DW-1:0] fb_s, ref_s, thr_s, rise_up, rise_down;
  logic                 stall_up, stall_down;
  logic                 dv, fin;
  logic [AW-1:0]        da;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_threshold <= sec_pkg::STALL_THRESHOLD_RESET;
      angle_step      <= sec_pkg::ANGLE_STEP_RESET;
      full_angle      <= sec_pkg::FULL_ANGLE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sec_pkg::CFG_STALL_THRESHOLD: stall_threshold <= cfg_data[sec_pkg::THRESH_W-1:0];
        sec_pkg::CFG_ANGLE_STEP:      angle_step      <= cfg_data[sec_pkg::STEP_W-1:0];
        sec_pkg::CFG_FULL_ANGLE:      full_angle      <= cfg_data[AW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign a_s     = $signed({{(SW-AW){1'b0}}, sweep_angle});
  assign st_s    = $signed({{(SW-sec_pkg::STEP_W){1'b0}}, angle_step});
  assign st2_s   = $signed({{(SW-sec_pkg::STEP_W-1){1'b0}}, angle_step, 1'b0});
  assign start_s = $signed({{(SW-AW){1'b0}}, start_angle});

  assign plus1      = sec_pkg::clamp_angle(a_s + st_s, full_angle);
  assign plus2      = sec_pkg::clamp_angle(a_s + st2_s, full_angle);
  assign minus1     = sec_pkg::clamp_angle(a_s - st_s, full_angle);
  assign minus2     = sec_pkg::clamp_angle(a_s - st2_s, full_angle);
  assign start_plus = sec_pkg::clamp_angle(start_s + st_s, full_angle);

  assign fb_s      = $signed({{(DW-FEEDBACK_BITS){1'b0}}, feedback});
  assign ref_s     = $signed({{(DW-FEEDBACK_BITS){1'b0}}, reference_feedback});
  assign thr_s     = $signed({{(DW-sec_pkg::THRESH_W){1'b0}}, stall_threshold});
  assign rise_up   = fb_s - ref_s;
  assign rise_down = ref_s - fb_s;
  assign stall_up   = rise_up < thr_s;
  assign stall_down = rise_down < thr_s;

  always_comb begin
    phase_next              = phase;
    sweep_angle_next        = sweep_angle;
    reference_feedback_next = reference_feedback;
    lower_limit_reg_next    = lower_limit_reg;
    upper_limit_reg_next    = upper_limit_reg;
    dv  = 1'b0;
    da  = '0;
    fin = 1'b0;
    case (sec_pkg::op_t'(op))
      sec_pkg::OP_START: begin
        phase_next              = sec_pkg::PH_UP;
        reference_feedback_next = feedback;
        sweep_angle_next        = start_plus;
        dv = 1'b1;
        da = start_plus;
      end
      sec_pkg::OP_SAMPLE: begin
        case (phase)
          sec_pkg::PH_UP: begin
            if (stall_up) begin
              upper_limit_reg_next = minus1;
              sweep_angle_next     = minus2;
              phase_next           = sec_pkg::PH_REREF;
              dv = 1'b1;
              da = minus2;
            end else begin
              reference_feedback_next = feedback;
              if (sweep_angle >= full_angle) begin
                upper_limit_reg_next = full_angle;
                phase_next           = sec_pkg::PH_REREF;
              end else begin
                sweep_angle_next = plus1;
                dv = 1'b1;
                da = plus1;
              end
            end
          end
          sec_pkg::PH_REREF: begin
            reference_feedback_next = feedback;
            sweep_angle_next        = minus1;
            phase_next              = sec_pkg::PH_DOWN;
            dv = 1'b1;
            da = minus1;
          end
          sec_pkg::PH_DOWN: begin
            if (stall_down) begin
              lower_limit_reg_next = plus1;
              sweep_angle_next     = plus2;
              phase_next           = sec_pkg::PH_IDLE;
              dv  = 1'b1;
              da  = plus2;
              fin = 1'b1;
            end else begin
              reference_feedback_next = feedback;
              if (sweep_angle == '0) begin
                lower_limit_reg_next = '0;
                phase_next           = sec_pkg::PH_IDLE;
                fin = 1'b1;
              end else begin
                sweep_angle_next = minus1;
                dv = 1'b1;
                da = minus1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      sec_pkg::OP_GO_HIGH: begin
        if (phase == sec_pkg::PH_IDLE) begin
          dv = 1'b1;
          da = upper_limit_reg;
        end
      end
      sec_pkg::OP_GO_LOW: begin
        if (phase == sec_pkg::PH_IDLE) begin
          dv = 1'b1;
          da = lower_limit_reg;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= sec_pkg::PH_IDLE;
      sweep_angle        <= '0;
      reference_feedback <= '0;
      lower_limit_reg    <= '0;
      upper_limit_reg    <= sec_pkg::FULL_ANGLE_RESET;
    end else if (advance) begin
      phase              <= phase_next;
      sweep_angle        <= sweep_angle_next;
      reference_feedback <= reference_feedback_next;
      lower_limit_reg    <= lower_limit_reg_next;
      upper_limit_reg    <= upper_limit_reg_next;
    end
  end

  always_comb begin
    result.drive_valid = dv;
    result.drive_angle = da;
    result.busy_res    = (phase_next != sec_pkg::PH_IDLE);
    result.low_limit   = lower_limit_reg_next;
    result.high_limit  = upper_limit_reg_next;
    result.finished    = fin;
  end

`ifndef SYNTHESIS
  a_fin_not_busy: assert property (@(posedge clk) disable iff (rst)
    advance && fin |-> phase_next == sec_pkg::PH_IDLE)
    else $error("finishing request leaves calibration busy");
  a_quiet_angle: assert property (@(posedge clk) disable iff (rst)
    advance && !dv |-> da == '0)
    else $error("angle driven without a command");
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(phase) && $stable(sweep_angle))
    else $error("state moved without a request");
`endif

endmodule

`default_nettype wire

### rtl/core/sec_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module sec_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              stall,
  input  wire sec_pkg::result_t  result_d,
  output logic                   valid,
  output sec_pkg::result_t       result_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/servo_endstop_calibrator.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     op, start_angle, feedback
// out      output     out_valid / out_stall   drive_valid, drive_angle, busy_res,
//                                             low_limit, high_limit, finished
// cfg      input      cfg_write               cfg_index, cfg_data
//
// Each request is held in the input register and then in the result register,
// where its result is presented until it is taken; one request is taken every
// cycle while the output is not stalled.
// Reset is synchronous; no clearing pass follows it.
// A stalled output holds its result; the input register then fills and the
// input stalls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module servo_endstop_calibrator #(
  parameter int FEEDBACK_BITS = sec_pkg::FEEDBACK_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [sec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sec_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    op,
  input  wire logic [sec_pkg::ANGLE_W-1:0]   start_angle,
  input  wire logic [FEEDBACK_BITS-1:0]      feedback,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               drive_valid,
  output logic [sec_pkg::ANGLE_W-1:0]        drive_angle,
  output logic                               busy_res,
  output logic [sec_pkg::ANGLE_W-1:0]        low_limit,
  output logic [sec_pkg::ANGLE_W-1:0]        high_limit,
  output logic                               finished
);

  logic                          in_full;
  logic                          in_load;
  logic                          advance;
  logic [1:0]                    op_q;
  logic [sec_pkg::ANGLE_W-1:0]   start_angle_q;
  logic [FEEDBACK_BITS-1:0]      feedback_q;
  sec_pkg::result_t              step_result;
  sec_pkg::result_t              out_result;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_load  = in_valid && !in_stall;

  sec_in_reg #(
    .FEEDBACK_BITS(FEEDBACK_BITS)
  ) u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (in_load),
    .advance      (advance),
    .op_d         (op),
    .start_angle_d(start_angle),
    .feedback_d   (feedback),
    .full         (in_full),
    .op_q         (op_q),
    .start_angle_q(start_angle_q),
    .feedback_q   (feedback_q)
  );

  sec_step #(
    .FEEDBACK_BITS(FEEDBACK_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (advance),
    .op         (op_q),
    .start_angle(start_angle_q),
    .feedback   (feedback_q),
    .result     (step_result)
  );

  sec_out_reg u_out_reg (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .stall   (out_stall),
    .result_d(step_result),
    .valid   (out_valid),
    .result_q(out_result)
  );

  assign drive_valid = out_result.drive_valid;
  assign drive_angle = out_result.drive_angle;
  assign busy_res    = out_result.busy_res;
  assign low_limit   = out_result.low_limit;
  assign high_limit  = out_result.high_limit;
  assign finished    = out_result.finished;

`ifndef SYNTHESIS
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed request did not reach the result register");
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && out_valid && out_stall)
    else $error("input stalled without a blocked result");
  a_finished_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !busy_res)
    else $error("finished result still reports busy");
`endif

endmodule

`default_nettype wire

### sim/servo_endstop_calibrator_tb.sv
`timescale 1ns / 1ps

module servo_endstop_calibrator_tb;

  localparam int FB_W = sec_pkg::FEEDBACK_BITS_DEFAULT;
  localparam int HOLD_CYCLES = 40;

  typedef logic [sec_pkg::ANGLE_W-1:0]  angle_t;
  typedef logic [FB_W-1:0]              fb_t;
  typedef logic [sec_pkg::THRESH_W-1:0] thresh_t;
  typedef logic [sec_pkg::STEP_W-1:0]   step_t;
  typedef logic [sec_pkg::CFG_W-1:0]    cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [sec_pkg::CFG_IDX_W-1:0] cfg_index = sec_pkg::CFG_STALL_THRESHOLD;
  cfg_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = sec_pkg::OP_START;
  angle_t start_angle = '0;
  fb_t feedback = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic drive_valid;
  angle_t drive_angle;
  logic busy_res;
  angle_t low_limit;
  angle_t high_limit;
  logic finished;

  // Calibrator state and register copies kept by the testbench.
  sec_pkg::phase_t phase_q = sec_pkg::PH_IDLE;
  angle_t sweep_pos = '0;
  fb_t ref_fb = '0;
  angle_t lower_lim = '0;
  angle_t upper_lim = sec_pkg::FULL_ANGLE_RESET;
  thresh_t thresh_cfg = sec_pkg::STALL_THRESHOLD_RESET;
  step_t step_cfg = sec_pkg::ANGLE_STEP_RESET;
  angle_t full_cfg = sec_pkg::FULL_ANGLE_RESET;

  sec_pkg::result_t pending_results[$];
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit error_seen = 1'b0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;

  servo_endstop_calibrator u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .start_angle (start_angle),
    .feedback    (feedback),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_valid (drive_valid),
    .drive_angle (drive_angle),
    .busy_res    (busy_res),
    .low_limit   (low_limit),
    .high_limit  (high_limit),
    .finished    (finished)
  );

  always #6 clk = ~clk;

  function automatic angle_t angle_sat(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > int'(full_cfg)) begin
      return full_cfg;
    end
    return v[sec_pkg::ANGLE_W-1:0];
  endfunction

  function automatic sec_pkg::result_t calib_predict(input sec_pkg::op_t cmd,
                                                     input angle_t sa, input fb_t fb);
    sec_pkg::result_t r;
    int a;
    int st;
    a = int'(sweep_pos);
    st = int'(step_cfg);
    r = '0;
    case (cmd)
      sec_pkg::OP_START: begin
        phase_q = sec_pkg::PH_UP;
        ref_fb = fb;
        sweep_pos = angle_sat(int'(sa) + st);
        r.drive_valid = 1'b1;
        r.drive_angle = sweep_pos;
      end
      sec_pkg::OP_SAMPLE: begin
        case (phase_q)
          sec_pkg::PH_UP: begin
            if (int'(fb) - int'(ref_fb) < int'(thresh_cfg)) begin
              upper_lim = angle_sat(a - st);
              sweep_pos = angle_sat(a - 2 * st);
              r.drive_valid = 1'b1;
              r.drive_angle = sweep_pos;
              phase_q = sec_pkg::PH_REREF;
            end else begin
              ref_fb = fb;
              if (a >= int'(full_cfg)) begin
                upper_lim = full_cfg;
                phase_q = sec_pkg::PH_REREF;
              end else begin
                sweep_pos = angle_sat(a + st);
                r.drive_valid = 1'b1;
                r.drive_angle = sweep_pos;
              end
            end
          end
          sec_pkg::PH_REREF: begin
            ref_fb = fb;
            sweep_pos = angle_sat(a - st);
            r.drive_valid = 1'b1;
            r.drive_angle = sweep_pos;
            phase_q = sec_pkg::PH_DOWN;
          end
          sec_pkg::PH_DOWN: begin
            if (int'(ref_fb) - int'(fb) < int'(thresh_cfg)) begin
              lower_lim = angle_sat(a + st);
              sweep_pos = angle_sat(a + 2 * st);
              r.drive_valid = 1'b1;
              r.drive_angle = sweep_pos;
              phase_q = sec_pkg::PH_IDLE;
              r.finished = 1'b1;
            end else begin
              ref_fb = fb;
              if (a == 0) begin
                lower_lim = '0;
                phase_q = sec_pkg::PH_IDLE;
                r.finished = 1'b1;
              end else begin
                sweep_pos = angle_sat(a - st);
                r.drive_valid = 1'b1;
                r.drive_angle = sweep_pos;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (phase_q == sec_pkg::PH_IDLE) begin
          r.drive_valid = 1'b1;
          r.drive_angle = (cmd == sec_pkg::OP_GO_HIGH) ? upper_lim : lower_lim;
        end
      end
    endcase
    r.busy_res = (phase_q != sec_pkg::PH_IDLE);
    r.low_limit = lower_lim;
    r.high_limit = upper_lim;
    return r;
  endfunction

  task automatic send_request(input sec_pkg::op_t cmd, input angle_t sa, input fb_t fb);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= cmd;
    start_angle <= sa;
    feedback <= fb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(calib_predict(cmd, sa, fb));
  endtask

  task automatic settle_block;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input thresh_t th, input step_t st, input angle_t fa);
    cfg_write <= 1'b1;
    cfg_index <= sec_pkg::CFG_STALL_THRESHOLD;
    cfg_data <= cfg_t'(th);
    @(posedge clk);
    cfg_index <= sec_pkg::CFG_ANGLE_STEP;
    cfg_data <= cfg_t'(st);
    @(posedge clk);
    cfg_index <= sec_pkg::CFG_FULL_ANGLE;
    cfg_data <= cfg_t'(fa);
    @(posedge clk);
    cfg_write <= 1'b0;
    thresh_cfg = th;
    step_cfg = st;
    full_cfg = fa;
  endtask

  task automatic randomize_config;
    thresh_t th;
    step_t st;
    angle_t fa;
    case ($urandom_range(4))
      0: th = '0;
      1: th = 10'd1023;
      default: th = thresh_t'($urandom_range(40));
    endcase
    case ($urandom_range(5))
      0: st = 7'd1;
      1: st = 7'd90;
      default: st = step_t'($urandom_range(1, 90));
    endcase
    case ($urandom_range(5))
      0: fa = 8'd1;
      1: fa = 8'd255;
      default: fa = angle_t'($urandom_range(1, 255));
    endcase
    apply_config(th, st, fa);
  endtask

  // Mostly well-formed calibration traffic, with some restarts and noise.
  task automatic random_request;
    int pick;
    int v;
    bit moved;
    sec_pkg::op_t cmd;
    angle_t sa;
    fb_t fb;
    pick = int'($urandom_range(99));
    sa = angle_t'($urandom_range(255));
    fb = fb_t'($urandom_range(1023));
    moved = ($urandom_range(99) < 78);
    cmd = sec_pkg::OP_SAMPLE;
    if (pick < 8) begin
      cmd = sec_pkg::op_t'($urandom_range(3));
    end else if (phase_q == sec_pkg::PH_IDLE) begin
      if (pick < 70) begin
        cmd = sec_pkg::OP_START;
        if ($urandom_range(3) != 0) begin
          sa = angle_t'($urandom_range(int'(full_cfg)));
        end
      end else if (pick < 80) begin
        cmd = sec_pkg::OP_GO_HIGH;
      end else if (pick < 90) begin
        cmd = sec_pkg::OP_GO_LOW;
      end
    end else if (pick < 12) begin
      cmd = sec_pkg::OP_START;
    end else if (pick < 15) begin
      cmd = ($urandom_range(1) != 0) ? sec_pkg::OP_GO_HIGH : sec_pkg::OP_GO_LOW;
    end else begin
      v = int'($urandom_range(1023));
      if (phase_q == sec_pkg::PH_UP) begin
        v = moved ? int'(ref_fb) + int'(thresh_cfg) + int'($urandom_range(60))
                  : int'(ref_fb) + int'(thresh_cfg) - 1 - int'($urandom_range(30));
      end else if (phase_q == sec_pkg::PH_DOWN) begin
        v = moved ? int'(ref_fb) - int'(thresh_cfg) - int'($urandom_range(60))
                  : int'(ref_fb) - int'(thresh_cfg) + 1 + int'($urandom_range(30));
      end
      if (v < 0) begin
        v = 0;
      end else if (v > 1023) begin
        v = 1023;
      end
      fb = v[FB_W-1:0];
    end
    send_request(cmd, sa, fb);
  endtask

  task automatic test_limits_after_reset;
    send_request(sec_pkg::OP_GO_HIGH, 8'd0, 10'd0);
    send_request(sec_pkg::OP_GO_LOW, 8'd255, 10'd1023);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd1023);
    settle_block;
  endtask

  task automatic test_sweep_to_end;
    apply_config(10'd5, 7'd10, 8'd180);
    send_request(sec_pkg::OP_START, 8'd150, 10'd100);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd200);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd300);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd400);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd900);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd905);
    settle_block;
  endtask

  task automatic test_stalls_and_overrides;
    send_request(sec_pkg::OP_START, 8'd255, 10'd1023);
    send_request(sec_pkg::OP_GO_HIGH, 8'd0, 10'd0);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd1023);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd0);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd300);
    send_request(sec_pkg::OP_START, 8'd20, 10'd500);
    send_request(sec_pkg::OP_START, 8'd100, 10'd0);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd3);
    send_request(sec_pkg::OP_GO_LOW, 8'd0, 10'd0);
    settle_block;
  endtask

  task automatic test_config_extremes;
    apply_config(10'd1023, 7'd90, 8'd255);
    send_request(sec_pkg::OP_START, 8'd0, 10'd0);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd1023);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd1023);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd1023);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd0);
    settle_block;
    apply_config(10'd0, 7'd0, 8'd1);
    send_request(sec_pkg::OP_START, 8'd200, 10'd10);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd10);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd20);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd20);
    send_request(sec_pkg::OP_SAMPLE, 8'd0, 10'd25);
    settle_block;
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (3) begin
      settle_block;
      randomize_config;
      repeat (105) random_request;
    end
    settle_block;
  endtask

  // The receiver holds off while requests keep coming, so the block fills up.
  task automatic test_output_hold;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    apply_config(10'd5, 7'd10, 8'd180);
    hold_epoch <= hold_epoch + 1;
    repeat (16) random_request;
    settle_block;
  endtask

  always @(posedge clk) begin
    if (hold_epoch != hold_seen) begin
      hold_seen <= hold_epoch;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic check_field(input string field_name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want_v, got_v);
      error_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    sec_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive_valid %0d angle %0d",
                 $time, drive_valid, drive_angle);
        error_seen = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("drive_valid", int'(want.drive_valid), int'(drive_valid));
        check_field("drive_angle", int'(want.drive_angle), int'(drive_angle));
        check_field("busy_res", int'(want.busy_res), int'(busy_res));
        check_field("low_limit", int'(want.low_limit), int'(low_limit));
        check_field("high_limit", int'(want.high_limit), int'(high_limit));
        check_field("finished", int'(want.finished), int'(finished));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_limits_after_reset;
    test_sweep_to_end;
    test_stalls_and_overrides;
    test_config_extremes;
    test_random_traffic(13, 77);
    test_random_traffic(77, 13);
    test_random_traffic(0, 0);
    test_output_hold;
    settle_block;
    if (!error_seen && pending_results.size() == 0) begin
      $display("servo_endstop_calibrator verification clean");
    end else begin
      $display("servo_endstop_calibrator verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("servo_endstop_calibrator verification failed");
    $finish;
  end

endmodule
